>>> sv/psa_pkg.sv
`default_nettype none
package psa_pkg;

   // Number of coordinate dimensions, clamped to the supported range.
   localparam int NUM_DIMS  = 4;
   localparam int DIMS_USED = (NUM_DIMS < 1) ? 1 : ((NUM_DIMS > 4) ? 4 : NUM_DIMS);
   localparam int DIM_W     = 2;

   localparam int COORD_W = 32;
   localparam int SUM_W   = 48;
   localparam int CNT_W   = 32;

   localparam logic signed [SUM_W-1:0] S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [SUM_W-1:0]        U48_MAX = {SUM_W{1'b1}};

   // Statistics that one dimension lane reports to the output stage.
   typedef struct packed {
      logic signed [COORD_W-1:0] coord_min;
      logic signed [COORD_W-1:0] coord_max;
      logic signed [SUM_W-1:0]   coord_total;
      logic [SUM_W-1:0]          approx_variance;
   } lane_stat_type;

   // Saturating signed add of a 48-bit sum and a 32-bit value.
   function automatic logic signed [SUM_W-1:0] sat_add_s48(
      input logic signed [SUM_W-1:0]   a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {{(SUM_W+1-COORD_W){b[COORD_W-1]}}, b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? S48_MIN : S48_MAX;
      end
      return s[SUM_W-1:0];
   endfunction

   // Saturating unsigned add of two 48-bit values.
   function automatic logic [SUM_W-1:0] sat_add_u48(
      input logic [SUM_W-1:0] a,
      input logic [SUM_W-1:0] b
   );
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? U48_MAX : s[SUM_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/point_stats_accumulator_unit.sv
`default_nettype none
// An accepted word runs through load, the 48-step restoring divider,
// deviation, multiply and accumulate in each dimension lane before results.
// A new point is taken only once every result word has left; results leave at
// one word per cycle while rsp_ready is high, one per dimension.
// Reset: synchronous; clears counts and sums, sets minimum and maximum to
// their extreme values, no clearing pass.
module point_stats_accumulator_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [psa_pkg::COORD_W-1:0] req_signal_value,
   input  wire logic [psa_pkg::COORD_W-1:0]        req_error_sq_value,
   input  wire logic signed [psa_pkg::COORD_W-1:0] req_coord_0,
   input  wire logic signed [psa_pkg::COORD_W-1:0] req_coord_1,
   input  wire logic signed [psa_pkg::COORD_W-1:0] req_coord_2,
   input  wire logic signed [psa_pkg::COORD_W-1:0] req_coord_3,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [psa_pkg::DIM_W-1:0]               rsp_dim_index,
   output logic signed [psa_pkg::COORD_W-1:0]      rsp_coord_min,
   output logic signed [psa_pkg::COORD_W-1:0]      rsp_coord_max,
   output logic signed [psa_pkg::SUM_W-1:0]        rsp_coord_total,
   output logic [psa_pkg::SUM_W-1:0]               rsp_approx_variance,
   output logic signed [psa_pkg::SUM_W-1:0]        rsp_signal_total,
   output logic [psa_pkg::SUM_W-1:0]               rsp_error_total,
   output logic [psa_pkg::CNT_W-1:0]               rsp_point_count,
   output logic                                    rsp_last_of_run
);
   import psa_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_SEND = 2'd2;

   localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(DIMS_USED - 1);

   logic [1:0]              state_ff, state_in;
   logic [DIM_W-1:0]        dim_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sig_ff;
   logic [SUM_W-1:0]        err_ff;

   logic                      take, give;
   logic signed [COORD_W-1:0] coords [4];
   logic [DIMS_USED-1:0]      busy;
   lane_stat_type             stats [DIMS_USED];
   lane_stat_type             sel;

   assign take = req_valid && req_ready;
   assign give = rsp_valid && rsp_ready;

   assign coords[0] = req_coord_0;
   assign coords[1] = req_coord_1;
   assign coords[2] = req_coord_2;
   assign coords[3] = req_coord_3;

   assign count_in = (count_ff == {CNT_W{1'b1}}) ? count_ff : count_ff + 32'd1;

   // One lane per used dimension.
   for (genvar g = 0; g < DIMS_USED; g++) begin : g_lane
      psa_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (take),
         .coord (coords[g]),
         .count (count_in),
         .busy  (busy[g]),
         .stat  (stats[g])
      );
   end

   // Control sequence: take a word, wait for the lanes, send one word per dimension.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (take) state_in = S_CALC;
         S_CALC: if (busy == '0) state_in = S_SEND;
         S_SEND: if (give && dim_ff == LAST_DIM) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dim_ff   <= '0;
         count_ff <= '0;
         sig_ff   <= '0;
         err_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (take) begin
            count_ff <= count_in;
            sig_ff   <= sat_add_s48(sig_ff, req_signal_value);
            err_ff   <= sat_add_u48(err_ff, {16'd0, req_error_sq_value});
            dim_ff   <= '0;
         end else if (give) begin
            dim_ff <= dim_ff + 2'd1;
         end
      end
   end

   // Merge: select the lane for the current dimension.
   assign sel = stats[dim_ff];

   assign req_ready           = state_ff == S_IDLE;
   assign rsp_valid           = state_ff == S_SEND;
   assign rsp_dim_index       = dim_ff;
   assign rsp_coord_min       = sel.coord_min;
   assign rsp_coord_max       = sel.coord_max;
   assign rsp_coord_total     = sel.coord_total;
   assign rsp_approx_variance = sel.approx_variance;
   assign rsp_signal_total    = sig_ff;
   assign rsp_error_total     = err_ff;
   assign rsp_point_count     = count_ff;
   assign rsp_last_of_run     = dim_ff == LAST_DIM;

   // A result is only shown once every lane has finished.
   a_send_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy == '0) else $error("result shown while a lane is busy");

   // An accepted word starts the lanes.
   a_take_calc: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == S_CALC && busy != '0)) else $error("lanes did not start");

   // The last result word returns the block to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (give && rsp_last_of_run) |=> req_ready) else $error("not idle after last word");

endmodule
`default_nettype wire

>>> sv/psa_lane.sv
`default_nettype none
module psa_lane (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [psa_pkg::COORD_W-1:0] coord,
   input  wire logic [psa_pkg::CNT_W-1:0]          count,
   output logic                                    busy,
   output psa_pkg::lane_stat_type                  stat
);
   import psa_pkg::*;

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_LOAD = 3'd1;
   localparam logic [2:0] L_DIV  = 3'd2;
   localparam logic [2:0] L_DEV  = 3'd3;
   localparam logic [2:0] L_MUL  = 3'd4;
   localparam logic [2:0] L_ACC  = 3'd5;

   localparam logic [5:0] DIV_LAST = 6'(SUM_W - 1);

   logic [2:0]                state_ff, state_in;
   logic signed [COORD_W-1:0] min_ff, max_ff, x_ff;
   logic signed [SUM_W-1:0]   total_ff;
   logic [SUM_W-1:0]          var_ff;
   logic [CNT_W-1:0]          div_ff;
   logic [SUM_W-1:0]          dvd_ff;
   logic [CNT_W-1:0]          rem_ff;
   logic [5:0]                step_ff;
   logic                      neg_ff;
   logic [COORD_W-1:0]        mag_ff;
   logic                      over_ff;
   logic [2*COORD_W-1:0]      prod_ff;

   logic [CNT_W:0]            shifted;
   logic                      fits;
   logic signed [SUM_W-1:0]   mean;
   logic signed [SUM_W:0]     dev;
   logic [SUM_W:0]            dev_mag;
   logic [SUM_W-1:0]          term;

   // One restoring division step per cycle on the magnitude.
   assign shifted = {rem_ff, dvd_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   // Quotient truncated toward zero, then deviation of x from the mean.
   assign mean    = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);
   assign dev     = {{(SUM_W+1-COORD_W){x_ff[COORD_W-1]}}, x_ff} - {mean[SUM_W-1], mean};
   assign dev_mag = dev[SUM_W] ? 49'(-dev) : 49'(dev);
   assign term    = over_ff ? U48_MAX : prod_ff[2*COORD_W-1:16];

   // Lane sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE: if (start) state_in = L_LOAD;
         L_LOAD: state_in = L_DIV;
         L_DIV:  if (step_ff == DIV_LAST) state_in = L_DEV;
         L_DEV:  state_in = L_MUL;
         L_MUL:  state_in = L_ACC;
         L_ACC:  state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         min_ff   <= {1'b0, {(COORD_W-1){1'b1}}};
         max_ff   <= {1'b1, {(COORD_W-1){1'b0}}};
         total_ff <= '0;
         var_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == L_IDLE && start) begin
            if (coord < min_ff) min_ff <= coord;
            if (coord > max_ff) max_ff <= coord;
            total_ff <= sat_add_s48(total_ff, coord);
         end
         if (state_ff == L_ACC) begin
            var_ff <= sat_add_u48(var_ff, term);
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               x_ff   <= coord;
               div_ff <= count;
            end
         end
         L_LOAD: begin
            neg_ff  <= total_ff[SUM_W-1];
            dvd_ff  <= total_ff[SUM_W-1] ? 48'(-total_ff) : 48'(total_ff);
            rem_ff  <= '0;
            step_ff <= '0;
         end
         L_DIV: begin
            rem_ff  <= fits ? 32'(shifted - {1'b0, div_ff}) : shifted[CNT_W-1:0];
            dvd_ff  <= {dvd_ff[SUM_W-2:0], fits};
            step_ff <= step_ff + 6'd1;
         end
         L_DEV: begin
            mag_ff  <= dev_mag[COORD_W-1:0];
            over_ff <= |dev_mag[SUM_W:COORD_W];
         end
         L_MUL: begin
            prod_ff <= mag_ff * mag_ff;
         end
         default: begin
         end
      endcase
   end

   assign busy                 = state_ff != L_IDLE;
   assign stat.coord_min       = min_ff;
   assign stat.coord_max       = max_ff;
   assign stat.coord_total     = total_ff;
   assign stat.approx_variance = var_ff;

endmodule
`default_nettype wire

>>> dv/point_stats_accumulator_unit_tb.sv
`timescale 1ns / 1ps
module point_stats_accumulator_unit_tb;
   import psa_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 141;
   localparam int DRAIN_CYCLES = 80;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

   // One event point as offered on the input channel.
   typedef struct {
      logic signed [COORD_W-1:0] signal;
      logic [COORD_W-1:0]        err_sq;
      logic signed [COORD_W-1:0] coord [4];
      bit                        typed;
      logic [CNT_W-1:0]          typed_count;
      logic [SUM_W-1:0]          typed_signal;
      logic [SUM_W-1:0]          typed_error;
   } point_type;

   // Statistics expected in one result word.
   typedef struct {
      logic [DIM_W-1:0]          dim;
      logic signed [COORD_W-1:0] cmin;
      logic signed [COORD_W-1:0] cmax;
      logic [SUM_W-1:0]          total;
      logic [SUM_W-1:0]          variance;
      logic [SUM_W-1:0]          signal;
      logic [SUM_W-1:0]          error;
      logic [CNT_W-1:0]          count;
      logic                      last;
   } stats_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_signal_value = '0;
   logic [COORD_W-1:0]        req_error_sq_value = '0;
   logic signed [COORD_W-1:0] req_coord_0 = '0;
   logic signed [COORD_W-1:0] req_coord_1 = '0;
   logic signed [COORD_W-1:0] req_coord_2 = '0;
   logic signed [COORD_W-1:0] req_coord_3 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DIM_W-1:0]          rsp_dim_index;
   logic signed [COORD_W-1:0] rsp_coord_min;
   logic signed [COORD_W-1:0] rsp_coord_max;
   logic signed [SUM_W-1:0]   rsp_coord_total;
   logic [SUM_W-1:0]          rsp_approx_variance;
   logic signed [SUM_W-1:0]   rsp_signal_total;
   logic [SUM_W-1:0]          rsp_error_total;
   logic [CNT_W-1:0]          rsp_point_count;
   logic                      rsp_last_of_run;

   point_type      directed_points [$];
   stats_word_type expected_stats [$];
   int  points_sent = 0;
   int  points_taken = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;

   // Running statistics of the predictor.
   longint unsigned pred_count;
   longint          pred_signal;
   longint unsigned pred_error;
   longint          pred_min [4];
   longint          pred_max [4];
   longint          pred_total [4];
   longint unsigned pred_variance [4];

   always #10 clock = ~clock;

   point_stats_accumulator_unit dut (.*);

   function automatic longint clamp_s48(longint v);
      if (v > longint'(S48_MAX)) return longint'(S48_MAX);
      if (v < longint'(S48_MIN)) return longint'(S48_MIN);
      return v;
   endfunction

   function automatic longint unsigned add_u48(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > longint'(U48_MAX)) ? longint'(U48_MAX) : s;
   endfunction

   function automatic void clear_statistics();
      pred_count  = 0;
      pred_signal = 0;
      pred_error  = 0;
      for (int i = 0; i < 4; i++) begin
         pred_min[i]      = longint'(C_MAX);
         pred_max[i]      = longint'(C_MIN);
         pred_total[i]    = 0;
         pred_variance[i] = 0;
      end
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(point_type p);
      directed_points.insert(directed_points.size(), p);
   endfunction

   // Fold one point into the statistics and queue one word per used dimension.
   function automatic void fold_point(point_type p);
      longint          x;
      longint          mean;
      longint          dev;
      longint unsigned mag;
      longint unsigned term;
      stats_word_type  w;
      if (pred_count != 64'hFFFF_FFFF) pred_count++;
      pred_signal = clamp_s48(pred_signal + longint'(p.signal));
      pred_error  = add_u48(pred_error, longint'(p.err_sq));
      for (int i = 0; i < DIMS_USED; i++) begin
         x = longint'(p.coord[i]);
         if (x < pred_min[i]) pred_min[i] = x;
         if (x > pred_max[i]) pred_max[i] = x;
         pred_total[i] = clamp_s48(pred_total[i] + x);
         // Mean is formed after the total takes x; division truncates to zero.
         mean = pred_total[i] / longint'(pred_count);
         dev  = x - mean;
         mag  = (dev < 0) ? longint'(-dev) : longint'(dev);
         term = (mag >= 64'h1_0000_0000) ? longint'(U48_MAX) : ((mag * mag) >> 16);
         pred_variance[i] = add_u48(pred_variance[i], term);
         w.dim      = DIM_W'(i);
         w.cmin     = pred_min[i][COORD_W-1:0];
         w.cmax     = pred_max[i][COORD_W-1:0];
         w.total    = pred_total[i][SUM_W-1:0];
         w.variance = pred_variance[i][SUM_W-1:0];
         w.signal   = pred_signal[SUM_W-1:0];
         w.error    = pred_error[SUM_W-1:0];
         w.count    = pred_count[CNT_W-1:0];
         w.last     = (i == DIMS_USED - 1);
         if (p.typed) begin
            w.count  = p.typed_count;
            w.signal = p.typed_signal;
            w.error  = p.typed_error;
         end
         expected_stats.insert(expected_stats.size(), w);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("Mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_word(stats_word_type w);
      if (rsp_dim_index !== w.dim) report_mismatch("dim_index", rsp_dim_index, w.dim);
      if (rsp_coord_min !== w.cmin) report_mismatch("coord_min", rsp_coord_min, w.cmin);
      if (rsp_coord_max !== w.cmax) report_mismatch("coord_max", rsp_coord_max, w.cmax);
      if (rsp_coord_total !== w.total)
         report_mismatch("coord_total", rsp_coord_total, w.total);
      if (rsp_approx_variance !== w.variance)
         report_mismatch("approx_variance", rsp_approx_variance, w.variance);
      if (rsp_signal_total !== w.signal)
         report_mismatch("signal_total", rsp_signal_total, w.signal);
      if (rsp_error_total !== w.error)
         report_mismatch("error_total", rsp_error_total, w.error);
      if (rsp_point_count !== w.count)
         report_mismatch("point_count", rsp_point_count, w.count);
      if (rsp_last_of_run !== w.last)
         report_mismatch("last_of_run", rsp_last_of_run, w.last);
   endtask

   // Watch both channels at the rising edge.
   always @(posedge clock) begin
      point_type p;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p.signal = req_signal_value;
            p.err_sq = req_error_sq_value;
            p.coord[0] = req_coord_0;
            p.coord[1] = req_coord_1;
            p.coord[2] = req_coord_2;
            p.coord[3] = req_coord_3;
            p.typed = 1'b0;
            if (points_taken < directed_points.size()) p = directed_points[points_taken];
            fold_point(p);
            points_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               report_mismatch("unexpected word", rsp_dim_index, 0);
            end else begin
               check_word(expected_stats.pop_front());
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(10, 40);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 6))
         0: return C_MAX;
         1: return C_MIN;
         2: return '0;
         3: return $signed(32'($urandom_range(0, 20'hF_FFFF)) - 32'h8_0000);
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic point_type plain_point(logic signed [COORD_W-1:0] s,
                                             logic [COORD_W-1:0] e,
                                             logic signed [COORD_W-1:0] c0,
                                             logic signed [COORD_W-1:0] c1,
                                             logic signed [COORD_W-1:0] c2,
                                             logic signed [COORD_W-1:0] c3);
      point_type p;
      p.signal = s;
      p.err_sq = e;
      p.coord[0] = c0;
      p.coord[1] = c1;
      p.coord[2] = c2;
      p.coord[3] = c3;
      p.typed = 1'b0;
      p.typed_count = '0;
      p.typed_signal = '0;
      p.typed_error = '0;
      return p;
   endfunction

   function automatic point_type random_point();
      logic [COORD_W-1:0] e;
      e = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      return plain_point(pick_coord(), e, pick_coord(), pick_coord(), pick_coord(),
                         pick_coord());
   endfunction

   // Directed stimulus table; sums and counts are typed in for the first rows.
   initial begin
      point_type p;
      p = plain_point('0, '0, '0, '0, '0, '0);
      p.typed = 1'b1; p.typed_count = 1; p.typed_signal = '0; p.typed_error = '0;
      add_row(p);
      p = plain_point(C_MAX, 32'hFFFF_FFFF, C_MAX, C_MIN, C_MAX, C_MIN);
      p.typed = 1'b1; p.typed_count = 2;
      p.typed_signal = 48'h0000_7FFF_FFFF; p.typed_error = 48'h0000_FFFF_FFFF;
      add_row(p);
      p = plain_point(C_MIN, '0, C_MIN, C_MAX, C_MIN, C_MAX);
      p.typed = 1'b1; p.typed_count = 3;
      p.typed_signal = 48'hFFFF_FFFF_FFFF; p.typed_error = 48'h0000_FFFF_FFFF;
      add_row(p);
      // Alternating extremes drive the variance into saturation.
      for (int i = 0; i < 8; i++) begin
         add_row(plain_point(i[0] ? C_MIN : C_MAX, 32'hFFFF_FFFF,
                             i[0] ? C_MAX : C_MIN, i[0] ? C_MIN : C_MAX,
                             32'sh0000_0001, 32'shFFFF_FFFF));
      end
      // Small and fractional values, negative means that truncate toward zero.
      add_row(plain_point(32'sh0000_8000, 32'h0000_0001, -32'sh0000_0003,
                          32'sh0000_0003, 32'sh0001_0000, -32'sh0001_0000));
      add_row(plain_point(32'sh5555_5555, 32'hAAAA_AAAA, 32'sh5555_5555,
                          32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0));
      for (int i = 0; i < 6; i++) add_row(random_point());
   end

   // Sender: directed rows, then random points, with random gaps before any point.
   initial begin
      point_type p;
      int gap;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int n = 0; n < directed_points.size() + RANDOM_ITEMS; n++) begin
         p = (n < directed_points.size()) ? directed_points[n] : random_point();
         gap = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid = 1'b1;
         req_signal_value = p.signal;
         req_error_sq_value = p.err_sq;
         req_coord_0 = p.coord[0];
         req_coord_1 = p.coord[1];
         req_coord_2 = p.coord[2];
         req_coord_3 = p.coord[3];
         points_sent = n + 1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid = 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver: random stalls, plus one long hold-off once 40 points have been sent.
   initial begin
      bit held;
      int stall;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && points_sent >= 40) begin
            held = 1'b1;
            rsp_ready = 1'b0;
            for (int c = 0; c < 600; c++) @(negedge clock);
         end
         stall = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // End of run: wait for every expected word, then a short drain.
   initial begin
      clear_statistics();
      wait (stimulus_done);
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_stats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
